@@ src/indexed_insert_erase_array_unit_defines.svh @@
// Assertion macros shared by the RTL of the indexed insert/erase array unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INDEXED_INSERT_ERASE_ARRAY_UNIT_DEFINES_SVH
`define INDEXED_INSERT_ERASE_ARRAY_UNIT_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define IIEA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IIEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/iiea_pkg.sv @@
// Shared types and codes for the indexed insert/erase array unit.
// No dependencies; imported by iiea_cell and the top level.
package iiea_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_POP_BACK  = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_ERASE     = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_QUERY     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_KEEP,
    CELL_PUSH,
    CELL_INSERT,
    CELL_ERASE
  } cell_op_t;

  typedef struct packed {
    logic     en;
    cell_op_t op;
  } cell_ctl_t;

  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 4;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

endpackage

@@ src/iiea_cell.sv @@
// One storage cell of the array chain: holds one entry and trades it with its neighbors.
// Depends on iiea_pkg.
module iiea_cell #(
  parameter int INDEX        = 0,
  parameter int IDX_BITS     = 4,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                      clk,
  input  iiea_pkg::cell_ctl_t       ctl,
  input  logic [IDX_BITS-1:0]       sel,
  input  logic [IDX_BITS-1:0]       last_idx,
  input  logic [ELEMENT_BITS-1:0]   load_data,
  input  logic [ELEMENT_BITS-1:0]   left_data,
  input  logic [ELEMENT_BITS-1:0]   right_data,
  output logic [ELEMENT_BITS-1:0]   data,
  output logic [ELEMENT_BITS-1:0]   tail_data
);
  import iiea_pkg::*;

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

  logic [ELEMENT_BITS-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.en) begin
      case (ctl.op)
        CELL_PUSH: begin
          if (MY_IDX == sel) data_next = load_data;
        end
        CELL_INSERT: begin
          // shift up above the slot, load the slot itself
          if (MY_IDX > sel) data_next = left_data;
          else if (MY_IDX == sel) data_next = load_data;
        end
        CELL_ERASE: begin
          if (MY_IDX >= sel) data_next = right_data;
        end
        default: data_next = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign tail_data = (MY_IDX == last_idx) ? data : '0;

endmodule

@@ src/indexed_insert_erase_array_unit.sv @@
// Top level of the indexed insert/erase array unit: command decode, count, result register.
// Depends on iiea_pkg, iiea_cell and indexed_insert_erase_array_unit_defines.svh.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+-------------------------
//   in      | command, position, value                  | in_valid && in_ready
//   out     | status, count, is_empty, front_value,     | out_valid && out_ready
//           | back_value                                |
//
// Order: a command updates the cells it touches at the edge of its transfer and sets the
//   pending flag; the result register loads from the cells when the pending stage drains,
//   so out_valid rises after the pending stage and can wait behind a held result.
// Throughput: one command per cycle while the result side keeps up; the result stage
//   (pending flag) and the output register each hold one command.
// Reset: clears the entry count and all valid flags; cell contents are left as they are.
// Stalls: a held result blocks the pending stage, which then drops in_ready.
`include "indexed_insert_erase_array_unit_defines.svh"

module indexed_insert_erase_array_unit #(
  parameter int CAPACITY     = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iiea_pkg::CMD_BITS-1:0]       command,
  input  logic [iiea_pkg::POS_BITS-1:0]       position,
  input  logic [iiea_pkg::VALUE_BITS-1:0]     value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [iiea_pkg::STATUS_BITS-1:0]    status,
  output logic [iiea_pkg::COUNT_BITS-1:0]     count,
  output logic                                is_empty,
  output logic [iiea_pkg::VALUE_BITS-1:0]     front_value,
  output logic [iiea_pkg::VALUE_BITS-1:0]     back_value
);
  import iiea_pkg::*;

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);
  localparam logic [CNT_BITS-1:0] CNT_ONE    = CNT_BITS'(1);

  // Control state
  logic [CNT_BITS-1:0] entry_count;
  logic [CNT_BITS-1:0] entry_count_next;
  logic                pend;
  status_t             pend_status;
  status_t             cmd_status;

  logic in_fire;
  logic out_free;
  logic out_load;

  cell_ctl_t               cell_ctl;
  logic [IDX_BITS-1:0]     cell_sel;
  logic [IDX_BITS-1:0]     last_idx;
  logic [ELEMENT_BITS-1:0] load_data;
  logic [ELEMENT_BITS-1:0] cell_data [CAPACITY];
  logic [ELEMENT_BITS-1:0] cell_tail [CAPACITY];
  logic [ELEMENT_BITS-1:0] tail_value;

  logic [CMP_BITS-1:0] pos_cmp;
  logic [CMP_BITS-1:0] cnt_cmp;
  logic                pos_bad;
  logic                is_full;

  // Transfer control: the pending stage drains into the output register when it is free.
  assign out_free = !out_valid || out_ready;
  assign out_load = pend && out_free;
  assign in_ready = !pend || out_free;
  assign in_fire  = in_valid && in_ready;

  assign pos_cmp   = CMP_BITS'(position);
  assign cnt_cmp   = CMP_BITS'(entry_count);
  assign pos_bad   = pos_cmp >= cnt_cmp;
  assign is_full   = entry_count >= FULL_COUNT;
  assign load_data = ELEMENT_BITS'(value);

  // Decode: status, new count, and the broadcast to the cell chain.
  always_comb begin
    cmd_status       = ST_DONE;
    entry_count_next = entry_count;
    cell_ctl.en      = 1'b0;
    cell_ctl.op      = CELL_KEEP;
    cell_sel         = IDX_BITS'(position);
    case (cmd_t'(command))
      CMD_APPEND: begin
        cell_sel = IDX_BITS'(entry_count);
        if (is_full) begin
          cmd_status = ST_FULL;
        end else begin
          cell_ctl.op      = CELL_PUSH;
          entry_count_next = entry_count + CNT_ONE;
        end
      end
      CMD_POP_BACK: begin
        if (entry_count == '0) cmd_status = ST_IGNORED;
        else entry_count_next = entry_count - CNT_ONE;
      end
      CMD_INSERT: begin
        // bad position wins over full
        if (pos_bad) begin
          cmd_status = ST_IGNORED;
        end else if (is_full) begin
          cmd_status = ST_FULL;
        end else begin
          cell_ctl.op      = CELL_INSERT;
          entry_count_next = entry_count + CNT_ONE;
        end
      end
      CMD_ERASE: begin
        if (pos_bad) begin
          cmd_status = ST_IGNORED;
        end else begin
          cell_ctl.op      = CELL_ERASE;
          entry_count_next = entry_count - CNT_ONE;
        end
      end
      CMD_CLEAR: entry_count_next = '0;
      default: entry_count_next = entry_count;  // query and unused codes
    endcase
    cell_ctl.en = in_fire && (cell_ctl.op != CELL_KEEP);
  end

  // Cell chain: each cell sees its two neighbors; the ends feed back their own entry.
  assign last_idx = IDX_BITS'(entry_count - CNT_ONE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_in;
    logic [ELEMENT_BITS-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = cell_data[i];
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end
    iiea_cell #(
      .INDEX        (i),
      .IDX_BITS     (IDX_BITS),
      .ELEMENT_BITS (ELEMENT_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .sel        (cell_sel),
      .last_idx   (last_idx),
      .load_data  (load_data),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .tail_data  (cell_tail[i])
    );
  end

  // Only the cell that matches the last index drives a nonzero tail; OR them together.
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_value = tail_value | cell_tail[i];
    end
  end

  // Control registers: count, pending stage, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) entry_count <= entry_count_next;
      if (in_fire) pend <= 1'b1;
      else if (out_load) pend <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers: hold status through the pending stage, then build the result.
  always_ff @(posedge clk) begin
    if (in_fire) pend_status <= cmd_status;
    if (out_load) begin
      status   <= pend_status;
      count    <= COUNT_BITS'(entry_count);
      is_empty <= (entry_count == '0);
      if (entry_count == '0) begin
        front_value <= '0;
        back_value  <= '0;
      end else begin
        front_value <= VALUE_BITS'(cell_data[0]);
        back_value  <= VALUE_BITS'(tail_value);
      end
    end
  end

  `IIEA_ASSERT(a_count_in_range, clk, rst, entry_count <= FULL_COUNT, "entry count beyond capacity")
  `IIEA_ASSERT(a_fire_sets_pend, clk, rst, in_fire |=> pend, "accepted command not pending")
  `IIEA_ASSERT(a_empty_zero, clk, rst, (out_valid && is_empty) |-> (front_value == '0 && back_value == '0), "empty result carries data")
  `IIEA_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!pend && !out_valid), "not idle after reset")

endmodule
